@@ sv/jfc_pkg.sv @@
// Shared types and constants for the camera frame capture block.
// No dependencies.
`default_nettype none

package jfc_pkg;

  localparam int JFC_BANK_BYTES    = 32768;
  localparam int JFC_SAMPLE_WINDOW = 4096;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;

  // Per-word scan result: byte counts and marker hits by pair lane.
  // A pair lane j means the marker pair starts one byte before byte j.
  typedef struct packed {
    logic [2:0] nz_add;
    logic [2:0] ff_add;
    logic       soi_hit;
    logic [1:0] soi_lane;
    logic       eoi_hit;
    logic [1:0] eoi_lane;
  } jfc_scan_t;

  // Status fields as they appear on the result channel.
  typedef struct packed {
    logic               frame_ready;
    logic [15:0]        ready_size;
    logic [15:0]        capture_size;
    logic signed [15:0] soi_position;
    logic signed [15:0] eoi_position;
    logic [12:0]        nonzero_count;
    logic [12:0]        ff_byte_count;
    logic [31:0]        frame_end_count;
    logic [31:0]        rise_count;
    logic [31:0]        fall_count;
    logic               frame_ended;
  } jfc_status_t;

endpackage

`default_nettype wire

@@ sv/jfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module jfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/jfc_scan.sv @@
// Scans one committed 32-bit word: nonzero/0xFF counts and JPEG marker pairs.
// Depends on jfc_pkg.
`default_nettype none

module jfc_scan
  import jfc_pkg::*;
(
  input  wire logic [31:0] word,
  input  wire logic [7:0]  prev_byte,
  input  wire logic [3:0]  in_window,
  output jfc_scan_t        scan
);

  logic [7:0] cur  [4];
  logic [7:0] left [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      cur[j] = word[8*j +: 8];
    end
    left[0] = prev_byte;
    for (int j = 1; j < 4; j++) begin
      left[j] = cur[j-1];
    end
  end

  always_comb begin
    scan = '0;
    for (int j = 0; j < 4; j++) begin
      if (in_window[j] && cur[j] != 8'h00) begin
        scan.nz_add = scan.nz_add + 3'd1;
      end
      if (in_window[j] && cur[j] == MARK_FF) begin
        scan.ff_add = scan.ff_add + 3'd1;
      end
    end
    // first SOI wins: walk downward so the lowest lane is written last
    for (int j = 3; j >= 0; j--) begin
      if (left[j] == MARK_FF && cur[j] == MARK_SOI) begin
        scan.soi_hit  = 1'b1;
        scan.soi_lane = 2'(j);
      end
    end
    // last EOI wins
    for (int j = 0; j < 4; j++) begin
      if (left[j] == MARK_FF && cur[j] == MARK_EOI) begin
        scan.eoi_hit  = 1'b1;
        scan.eoi_lane = 2'(j);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/jpeg_frame_capture_double_buffer.sv @@
// Camera byte capture into a two-bank frame store with per-frame statistics.
// Depends on jfc_pkg, jfc_ram, jfc_scan.
//
// One item is taken every clock cycle unless in_stall holds it; its result passes
// the frame store read and then the output register. Bytes are packed four
// to a word and written through the single write port of the frame store;
// byte reads use its read port, always in the bank opposite the write bank,
// so the two never touch the same entry. Statistics and markers are updated
// per committed word. The store is not cleared after reset: a byte read returns
// store contents only once a frame has been swapped in, and only below its size.
// The config write is taken at any cycle (cfg_ready is tied high) and must happen
// while the block idles.
`default_nettype none

module jpeg_frame_capture_double_buffer
  import jfc_pkg::*;
#(
  parameter int BANK_BYTES    = JFC_BANK_BYTES,
  parameter int SAMPLE_WINDOW = JFC_SAMPLE_WINDOW
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,
  // item channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         action,
  input  wire logic [7:0]         data_byte,
  input  wire logic               edge_rise,
  input  wire logic               edge_fall,
  input  wire logic [14:0]        read_address,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              read_data,
  output logic                    frame_ready,
  output logic [15:0]             ready_size,
  output logic [15:0]             capture_size,
  output logic signed [15:0]      soi_position,
  output logic signed [15:0]      eoi_position,
  output logic [12:0]             nonzero_count,
  output logic [12:0]             ff_byte_count,
  output logic [31:0]             frame_end_count,
  output logic [31:0]             rise_count,
  output logic [31:0]             fall_count,
  output logic                    frame_ended
);

  localparam int BANK_WORDS = BANK_BYTES / 4;
  localparam int WADDR_W    = $clog2(BANK_WORDS);
  localparam int RAM_AW     = WADDR_W + 1;
  localparam int RAM_DEPTH  = 2 << WADDR_W;
  localparam int SIZE_W     = $clog2(BANK_BYTES + 1);
  localparam int CNT_W      = $clog2(SAMPLE_WINDOW + 1);

  localparam logic [2:0] ACT_DATA    = 3'd0;
  localparam logic [2:0] ACT_EDGE    = 3'd1;
  localparam logic [2:0] ACT_LOCK    = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;

  // ---------------------------------------------------------------- state
  logic               end_on_rising;
  logic               write_bank, write_bank_next;
  logic [WADDR_W-1:0] word_count, word_count_next;
  logic [1:0]         byte_phase, byte_phase_next;
  logic [23:0]        partial_word, partial_word_next;
  logic               reader_locked, reader_locked_next;
  logic               ready_flag, ready_flag_next;
  logic [SIZE_W-1:0]  ready_bytes, ready_bytes_next;
  logic [SIZE_W-1:0]  last_bytes, last_bytes_next;
  logic               soi_valid, soi_valid_next;
  logic [SIZE_W-1:0]  soi_pos, soi_pos_next;
  logic               eoi_valid, eoi_valid_next;
  logic [SIZE_W-1:0]  eoi_pos, eoi_pos_next;
  logic [CNT_W-1:0]   nz_tally, nz_tally_next;
  logic [CNT_W-1:0]   ff_tally, ff_tally_next;
  logic [31:0]        end_cnt, end_cnt_next;
  logic [31:0]        rise_cnt, rise_cnt_next;
  logic [31:0]        fall_cnt, fall_cnt_next;
  // running statistics of the capture in progress
  logic [CNT_W-1:0]   run_nz, run_nz_next;
  logic [CNT_W-1:0]   run_ff, run_ff_next;
  logic               run_soi_valid, run_soi_valid_next;
  logic [SIZE_W-1:0]  run_soi, run_soi_next;
  logic               run_eoi_valid, run_eoi_valid_next;
  logic [SIZE_W-1:0]  run_eoi, run_eoi_next;
  logic [7:0]         prev_byte, prev_byte_next;

  // ---------------------------------------------------------------- pipe
  logic               p_valid;
  jfc_status_t        p_status;
  logic               p_hit;
  logic [1:0]         p_lane;
  logic               o_valid;
  jfc_status_t        o_status;
  logic [7:0]         o_read_data;

  logic               accept;
  logic               p_move;

  assign cfg_ready = 1'b1;
  assign p_move    = p_valid && (!o_valid || !out_stall);
  assign in_stall  = p_valid && o_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  // ---------------------------------------------------------------- word commit
  logic [31:0]        commit_word;
  logic               commit;
  logic               last_word;
  logic               edge_end;
  logic               frame_end;
  logic [SIZE_W-1:0]  base;
  logic [SIZE_W-1:0]  end_size;
  logic [3:0]         in_window;
  jfc_scan_t          scan;

  assign commit_word = {data_byte, partial_word};
  assign commit      = accept && action == ACT_DATA && byte_phase == 2'd3;
  assign last_word   = word_count == WADDR_W'(BANK_WORDS - 1);
  assign edge_end    = accept && action == ACT_EDGE &&
                       (end_on_rising ? edge_rise : edge_fall);
  assign frame_end   = (commit && last_word) || edge_end;
  assign base        = SIZE_W'({word_count, 2'b00});
  assign end_size    = commit ? base + SIZE_W'(4) : base;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      in_window[j] = (32'(base) + 32'(j)) < 32'(SAMPLE_WINDOW);
    end
  end

  jfc_scan u_scan (
    .word      (commit_word),
    .prev_byte (prev_byte),
    .in_window (in_window),
    .scan      (scan)
  );

  // ---------------------------------------------------------------- frame store
  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr;
  logic               ram_re;
  logic [RAM_AW-1:0]  ram_raddr;
  logic [31:0]        ram_rdata;

  assign ram_we    = commit;
  assign ram_waddr = {write_bank, word_count};
  assign ram_re    = accept && action == ACT_READ && ready_flag &&
                     32'(read_address) < 32'(ready_bytes) &&
                     32'(read_address) < 32'(BANK_BYTES);
  assign ram_raddr = {~write_bank, WADDR_W'(read_address[14:2])};

  jfc_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (commit_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- next state
  logic [CNT_W-1:0]   upd_nz, upd_ff;
  logic               upd_soi_valid, upd_eoi_valid;
  logic [SIZE_W-1:0]  upd_soi, upd_eoi;

  always_comb begin
    upd_nz        = run_nz;
    upd_ff        = run_ff;
    upd_soi_valid = run_soi_valid;
    upd_soi       = run_soi;
    upd_eoi_valid = run_eoi_valid;
    upd_eoi       = run_eoi;
    if (commit) begin
      upd_nz = run_nz + CNT_W'(scan.nz_add);
      upd_ff = run_ff + CNT_W'(scan.ff_add);
      if (!run_soi_valid && scan.soi_hit) begin
        upd_soi_valid = 1'b1;
        upd_soi       = base + SIZE_W'(scan.soi_lane) - SIZE_W'(1);
      end
      if (scan.eoi_hit) begin
        upd_eoi_valid = 1'b1;
        upd_eoi       = base + SIZE_W'(scan.eoi_lane) - SIZE_W'(1);
      end
    end
  end

  always_comb begin
    write_bank_next    = write_bank;
    word_count_next    = word_count;
    byte_phase_next    = byte_phase;
    partial_word_next  = partial_word;
    reader_locked_next = reader_locked;
    ready_flag_next    = ready_flag;
    ready_bytes_next   = ready_bytes;
    last_bytes_next    = last_bytes;
    soi_valid_next     = soi_valid;
    soi_pos_next       = soi_pos;
    eoi_valid_next     = eoi_valid;
    eoi_pos_next       = eoi_pos;
    nz_tally_next      = nz_tally;
    ff_tally_next      = ff_tally;
    end_cnt_next       = end_cnt;
    rise_cnt_next      = rise_cnt;
    fall_cnt_next      = fall_cnt;
    run_nz_next        = upd_nz;
    run_ff_next        = upd_ff;
    run_soi_valid_next = upd_soi_valid;
    run_soi_next       = upd_soi;
    run_eoi_valid_next = upd_eoi_valid;
    run_eoi_next       = upd_eoi;
    prev_byte_next     = commit ? data_byte : prev_byte;

    if (accept) begin
      unique case (action)
        ACT_DATA: begin
          if (byte_phase == 2'd3) begin
            byte_phase_next   = 2'd0;
            partial_word_next = '0;
            word_count_next   = word_count + WADDR_W'(1);
          end else begin
            byte_phase_next   = byte_phase + 2'd1;
            partial_word_next = partial_word;
            partial_word_next[8*byte_phase +: 8] = data_byte;
          end
        end
        ACT_EDGE: begin
          if (edge_rise) rise_cnt_next = rise_cnt + 32'd1;
          if (edge_fall) fall_cnt_next = fall_cnt + 32'd1;
        end
        ACT_LOCK: begin
          reader_locked_next = 1'b1;
        end
        ACT_RELEASE: begin
          ready_flag_next    = 1'b0;
          reader_locked_next = 1'b0;
        end
        ACT_CLEAR: begin
          end_cnt_next    = '0;
          rise_cnt_next   = '0;
          fall_cnt_next   = '0;
          last_bytes_next = '0;
          soi_valid_next  = 1'b0;
          eoi_valid_next  = 1'b0;
          nz_tally_next   = '0;
          ff_tally_next   = '0;
        end
        default: begin
        end
      endcase
    end

    if (frame_end) begin
      end_cnt_next = end_cnt + 32'd1;
      if (end_size != '0 && !reader_locked) begin
        write_bank_next  = ~write_bank;
        ready_bytes_next = end_size;
        ready_flag_next  = 1'b1;
      end
      last_bytes_next    = end_size;
      nz_tally_next      = upd_nz;
      ff_tally_next      = upd_ff;
      soi_valid_next     = upd_soi_valid;
      soi_pos_next       = upd_soi;
      eoi_valid_next     = upd_eoi_valid;
      eoi_pos_next       = upd_eoi;
      word_count_next    = '0;
      byte_phase_next    = 2'd0;
      partial_word_next  = '0;
      run_nz_next        = '0;
      run_ff_next        = '0;
      run_soi_valid_next = 1'b0;
      run_eoi_valid_next = 1'b0;
      prev_byte_next     = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_on_rising <= 1'b1;
      write_bank    <= 1'b0;
      word_count    <= '0;
      byte_phase    <= 2'd0;
      partial_word  <= '0;
      reader_locked <= 1'b0;
      ready_flag    <= 1'b0;
      ready_bytes   <= '0;
      last_bytes    <= '0;
      soi_valid     <= 1'b0;
      soi_pos       <= '0;
      eoi_valid     <= 1'b0;
      eoi_pos       <= '0;
      nz_tally      <= '0;
      ff_tally      <= '0;
      end_cnt       <= '0;
      rise_cnt      <= '0;
      fall_cnt      <= '0;
      run_nz        <= '0;
      run_ff        <= '0;
      run_soi_valid <= 1'b0;
      run_soi       <= '0;
      run_eoi_valid <= 1'b0;
      run_eoi       <= '0;
      prev_byte     <= 8'h00;
    end else begin
      if (cfg_valid && cfg_ready) begin
        end_on_rising <= cfg_data;
      end
      write_bank    <= write_bank_next;
      word_count    <= word_count_next;
      byte_phase    <= byte_phase_next;
      partial_word  <= partial_word_next;
      reader_locked <= reader_locked_next;
      ready_flag    <= ready_flag_next;
      ready_bytes   <= ready_bytes_next;
      last_bytes    <= last_bytes_next;
      soi_valid     <= soi_valid_next;
      soi_pos       <= soi_pos_next;
      eoi_valid     <= eoi_valid_next;
      eoi_pos       <= eoi_pos_next;
      nz_tally      <= nz_tally_next;
      ff_tally      <= ff_tally_next;
      end_cnt       <= end_cnt_next;
      rise_cnt      <= rise_cnt_next;
      fall_cnt      <= fall_cnt_next;
      run_nz        <= run_nz_next;
      run_ff        <= run_ff_next;
      run_soi_valid <= run_soi_valid_next;
      run_soi       <= run_soi_next;
      run_eoi_valid <= run_eoi_valid_next;
      run_eoi       <= run_eoi_next;
      prev_byte     <= prev_byte_next;
    end
  end

  // ---------------------------------------------------------------- result pipe
  jfc_status_t status_next;

  always_comb begin
    status_next.frame_ready     = ready_flag_next;
    status_next.ready_size      = 16'(ready_bytes_next);
    status_next.capture_size    = 16'(last_bytes_next);
    status_next.soi_position    = soi_valid_next ? 16'(soi_pos_next) : 16'hFFFF;
    status_next.eoi_position    = eoi_valid_next ? 16'(eoi_pos_next) : 16'hFFFF;
    status_next.nonzero_count   = 13'(nz_tally_next);
    status_next.ff_byte_count   = 13'(ff_tally_next);
    status_next.frame_end_count = end_cnt_next;
    status_next.rise_count      = rise_cnt_next;
    status_next.fall_count      = fall_cnt_next;
    status_next.frame_ended     = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (accept) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (p_move) begin
        o_valid <= 1'b1;
      end else if (!out_stall) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload registers; store read data holds while p waits since reads need a transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      p_status <= status_next;
      p_hit    <= ram_re;
      p_lane   <= read_address[1:0];
    end
    if (p_move) begin
      o_status    <= p_status;
      o_read_data <= p_hit ? ram_rdata[8*p_lane +: 8] : 8'h00;
    end
  end

  assign out_valid       = o_valid;
  assign read_data       = o_read_data;
  assign frame_ready     = o_status.frame_ready;
  assign ready_size      = o_status.ready_size;
  assign capture_size    = o_status.capture_size;
  assign soi_position    = o_status.soi_position;
  assign eoi_position    = o_status.eoi_position;
  assign nonzero_count   = o_status.nonzero_count;
  assign ff_byte_count   = o_status.ff_byte_count;
  assign frame_end_count = o_status.frame_end_count;
  assign rise_count      = o_status.rise_count;
  assign fall_count      = o_status.fall_count;
  assign frame_ended     = o_status.frame_ended;

  // ---------------------------------------------------------------- assertions
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr[RAM_AW-1] != ram_raddr[RAM_AW-1]))
    else $error("frame store write and read hit the same bank");

  a_ready_nonempty: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> (ready_bytes != '0))
    else $error("ready frame with zero size");

  a_locked_no_swap: assert property (@(posedge clk) disable iff (rst)
    (frame_end && reader_locked) |=> $stable(write_bank))
    else $error("bank swapped while reader locked");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> (word_count == '0 && byte_phase == 2'd0 && !run_soi_valid))
    else $error("capture state not cleared after frame end");

endmodule

`default_nettype wire

@@ sim/jpeg_frame_capture_double_buffer_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for jpeg_frame_capture_double_buffer: directed items, a long
// output hold-off and random frames under several idle mixes, each result checked
// against an in-bench model of the capture. Depends on jfc_pkg and the capture block RTL.

module jpeg_frame_capture_double_buffer_test;
  import jfc_pkg::*;

  localparam int BANK_WORDS   = JFC_BANK_BYTES / 4;
  localparam int RANDOM_ITEMS = 840;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [2:0] {
    ACT_BYTE    = 3'd0,
    ACT_VSYNC   = 3'd1,
    ACT_LOCK    = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_READ    = 3'd5,
    ACT_SPARE6  = 3'd6,
    ACT_SPARE7  = 3'd7
  } cam_action_e;

  typedef struct {
    logic [7:0]  read_data;
    jfc_status_t st;
  } cam_report_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         action = '0;
  logic [7:0]         data_byte = '0;
  logic               edge_rise = 1'b0;
  logic               edge_fall = 1'b0;
  logic [14:0]        read_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         read_data;
  logic               frame_ready;
  logic [15:0]        ready_size;
  logic [15:0]        capture_size;
  logic signed [15:0] soi_position;
  logic signed [15:0] eoi_position;
  logic [12:0]        nonzero_count;
  logic [12:0]        ff_byte_count;
  logic [31:0]        frame_end_count;
  logic [31:0]        rise_count;
  logic [31:0]        fall_count;
  logic               frame_ended;

  jpeg_frame_capture_double_buffer DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .data_byte(data_byte),
    .edge_rise(edge_rise), .edge_fall(edge_fall), .read_address(read_address),
    .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
    .frame_ready(frame_ready), .ready_size(ready_size), .capture_size(capture_size),
    .soi_position(soi_position), .eoi_position(eoi_position),
    .nonzero_count(nonzero_count), .ff_byte_count(ff_byte_count),
    .frame_end_count(frame_end_count), .rise_count(rise_count), .fall_count(fall_count),
    .frame_ended(frame_ended)
  );

  // bench control
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          recv_hold = 0;
  int          mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  cam_report_t due_status[$];

  // capture model state
  bit [31:0]          store_words [2*BANK_WORDS];
  bit                 end_rising;
  bit                 wr_bank;
  int unsigned        words_in;
  bit [1:0]           lane;
  bit [23:0]          held_bytes;
  bit                 locked;
  bit                 have_ready;
  bit [15:0]          ready_len;
  bit [15:0]          cap_len;
  logic signed [15:0] soi_mark;
  logic signed [15:0] eoi_mark;
  bit [12:0]          nz_mark;
  bit [12:0]          ff_mark;
  bit [31:0]          ends_n;
  bit [31:0]          rises_n;
  bit [31:0]          falls_n;
  int unsigned        nz_run;
  int unsigned        ff_run;
  int                 soi_run;
  int                 eoi_run;
  bit [7:0]           last_byte;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_capture();
    words_in   = 0;
    lane       = 0;
    held_bytes = 0;
    nz_run     = 0;
    ff_run     = 0;
    soi_run    = -1;
    eoi_run    = -1;
    last_byte  = 0;
  endfunction

  function automatic void clear_diagnostics();
    ends_n   = 0;
    rises_n  = 0;
    falls_n  = 0;
    cap_len  = 0;
    soi_mark = '1;
    eoi_mark = '1;
    nz_mark  = 0;
    ff_mark  = 0;
  endfunction

  function automatic void reset_capture_model();
    end_rising = 1'b1;
    wr_bank    = 1'b0;
    locked     = 1'b0;
    have_ready = 1'b0;
    ready_len  = 0;
    clear_diagnostics();
    restart_capture();
  endfunction

  function automatic void commit_word(bit [31:0] w);
    int unsigned off;
    bit [7:0]    b;
    store_words[int'(wr_bank) * BANK_WORDS + words_in] = w;
    for (int j = 0; j < 4; j++) begin
      b = w[8*j +: 8];
      off = words_in * 4 + j;
      if (off < JFC_SAMPLE_WINDOW) begin
        if (b != 8'h00) nz_run++;
        if (b == MARK_FF) ff_run++;
      end
      // marker pairs may straddle words
      if (off > 0 && last_byte == MARK_FF) begin
        if (b == MARK_SOI && soi_run < 0) soi_run = int'(off) - 1;
        if (b == MARK_EOI) eoi_run = int'(off) - 1;
      end
      last_byte = b;
    end
    words_in++;
  endfunction

  function automatic void close_frame();
    int unsigned size;
    size = words_in * 4;
    ends_n++;
    if (size > 0 && !locked) begin
      wr_bank    = ~wr_bank;
      ready_len  = 16'(size);
      have_ready = 1'b1;
    end
    cap_len  = 16'(size);
    nz_mark  = 13'(nz_run);
    ff_mark  = 13'(ff_run);
    soi_mark = 16'(soi_run);
    eoi_mark = 16'(eoi_run);
    restart_capture();
  endfunction

  function automatic cam_report_t predict_capture(cam_action_e act, logic [7:0] b, logic r,
                                                  logic f, logic [14:0] a);
    cam_report_t rep;
    bit [31:0]   w;
    bit          ended;
    ended = 1'b0;
    rep.read_data = 8'h00;
    case (act)
      ACT_BYTE: begin
        if (lane == 2'd3) begin
          commit_word({b, held_bytes});
          lane = 0;
          held_bytes = 0;
          if (words_in >= BANK_WORDS) begin
            close_frame();
            ended = 1'b1;
          end
        end else begin
          held_bytes[8*lane +: 8] = b;
          lane++;
        end
      end
      ACT_VSYNC: begin
        if (r) rises_n++;
        if (f) falls_n++;
        if (end_rising ? r : f) begin
          close_frame();
          ended = 1'b1;
        end
      end
      ACT_LOCK: locked = 1'b1;
      ACT_RELEASE: begin
        have_ready = 1'b0;
        locked     = 1'b0;
      end
      ACT_CLEAR: clear_diagnostics();
      ACT_READ: begin
        if (have_ready && a < ready_len) begin
          w = store_words[int'(!wr_bank) * BANK_WORDS + a[14:2]];
          rep.read_data = w[8*a[1:0] +: 8];
        end
      end
      default: ;
    endcase
    rep.st.frame_ready     = have_ready;
    rep.st.ready_size      = ready_len;
    rep.st.capture_size    = cap_len;
    rep.st.soi_position    = soi_mark;
    rep.st.eoi_position    = eoi_mark;
    rep.st.nonzero_count   = nz_mark;
    rep.st.ff_byte_count   = ff_mark;
    rep.st.frame_end_count = ends_n;
    rep.st.rise_count      = rises_n;
    rep.st.fall_count      = falls_n;
    rep.st.frame_ended     = ended;
    return rep;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
  endtask

  // result side: random stall, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    cam_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_status.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'd1, 32'd0);
      end else begin
        want = due_status.pop_front();
        if (read_data !== want.read_data)
          flag_mismatch("read_data", read_data, want.read_data);
        if (frame_ready !== want.st.frame_ready)
          flag_mismatch("frame_ready", frame_ready, want.st.frame_ready);
        if (ready_size !== want.st.ready_size)
          flag_mismatch("ready_size", ready_size, want.st.ready_size);
        if (capture_size !== want.st.capture_size)
          flag_mismatch("capture_size", capture_size, want.st.capture_size);
        if (soi_position !== want.st.soi_position)
          flag_mismatch("soi_position", soi_position, want.st.soi_position);
        if (eoi_position !== want.st.eoi_position)
          flag_mismatch("eoi_position", eoi_position, want.st.eoi_position);
        if (nonzero_count !== want.st.nonzero_count)
          flag_mismatch("nonzero_count", nonzero_count, want.st.nonzero_count);
        if (ff_byte_count !== want.st.ff_byte_count)
          flag_mismatch("ff_byte_count", ff_byte_count, want.st.ff_byte_count);
        if (frame_end_count !== want.st.frame_end_count)
          flag_mismatch("frame_end_count", frame_end_count, want.st.frame_end_count);
        if (rise_count !== want.st.rise_count)
          flag_mismatch("rise_count", rise_count, want.st.rise_count);
        if (fall_count !== want.st.fall_count)
          flag_mismatch("fall_count", fall_count, want.st.fall_count);
        if (frame_ended !== want.st.frame_ended)
          flag_mismatch("frame_ended", frame_ended, want.st.frame_ended);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // one transfer on the item channel; the expectation is queued once it is taken
  task automatic send_item(cam_action_e act, logic [7:0] b, logic r, logic f, logic [14:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    data_byte    <= b;
    edge_rise    <= r;
    edge_fall    <= f;
    read_address <= a;
    do @(posedge clk); while (in_stall);
    due_status.push_back(predict_capture(act, b, r, f, a));
    if (act != ACT_SPARE6 && act != ACT_SPARE7) items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(ACT_BYTE, b, 1'($urandom), 1'($urandom), 15'($urandom));
  endtask

  task automatic send_read(logic [14:0] a);
    send_item(ACT_READ, 8'($urandom), 1'($urandom), 1'($urandom), a);
  endtask

  task automatic send_cmd(cam_action_e act);
    send_item(act, 8'($urandom), 1'($urandom), 1'($urandom), 15'($urandom));
  endtask

  // selected edge always set, the other one random
  task automatic send_frame_end();
    send_item(ACT_VSYNC, 8'($urandom), 1'(end_rising | $urandom_range(1)),
              1'(!end_rising | $urandom_range(1)), 15'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_end_edge(bit rising);
    cfg_valid <= 1'b1;
    cfg_data  <= rising;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    end_rising = rising;
  endtask

  task automatic test_directed();
    logic [7:0] jpeg_bytes [9];
    jpeg_bytes = '{8'hFF, 8'hD8, 8'h00, 8'hFF, 8'hD9, 8'h12, 8'h34, 8'h56, 8'hAB};
    send_read(15'd0);
    send_read(15'h7FFF);
    send_item(ACT_SPARE6, 8'hFF, 1'b1, 1'b1, 15'h7FFF);
    send_item(ACT_SPARE7, 8'h00, 1'b0, 1'b0, 15'd0);
    send_item(ACT_VSYNC, 8'h00, 1'b0, 1'b1, 15'd0);   // falling only: counted, no end
    send_item(ACT_VSYNC, 8'h00, 1'b1, 1'b0, 15'd0);   // empty frame ends without swap
    // last byte is an unfinished word and gets dropped
    foreach (jpeg_bytes[i]) send_byte(jpeg_bytes[i]);
    send_item(ACT_VSYNC, 8'hFF, 1'b1, 1'b1, 15'h7FFF);
    send_read(15'd0);
    send_read(15'd7);
    send_read(15'd8);
    send_cmd(ACT_LOCK);
    repeat (4) send_byte(8'h01);
    send_frame_end();
    send_read(15'd3);
    send_cmd(ACT_RELEASE);
    send_read(15'd0);
    send_cmd(ACT_CLEAR);
    wait_idle();
  endtask

  // output held off while items keep coming, so the input side has to stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 200;
    repeat (100) send_byte(8'($urandom));
    send_frame_end();
    repeat (8) send_read(15'($urandom_range(127)));
    wait_idle();
  endtask

  task automatic random_sequence();
    int         len;
    bit         head;
    bit         tail;
    logic [7:0] b;
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(9) == 0) send_cmd(ACT_LOCK);
      len  = ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(48);
      head = ($urandom_range(2) != 0);
      tail = ($urandom_range(2) != 0);
      for (int i = 0; i < len; i++) begin
        if (head && i < 2) begin
          b = (i == 0) ? MARK_FF : MARK_SOI;
        end else if (tail && len >= 4 && i >= len - 2) begin
          b = (i == len - 2) ? MARK_FF : MARK_EOI;
        end else begin
          case ($urandom_range(9))
            0, 1: b = MARK_FF;
            2: b = $urandom_range(1) ? MARK_SOI : MARK_EOI;
            3: b = 8'h00;
            default: b = 8'($urandom);
          endcase
        end
        send_byte(b);
      end
      send_frame_end();
      repeat ($urandom_range(4)) begin
        if (ready_len != 0 && $urandom_range(3) != 0)
          send_read(15'($urandom_range(ready_len - 1)));
        else send_read(15'($urandom));
      end
      if ($urandom_range(2) == 0) send_cmd(ACT_RELEASE);
      if ($urandom_range(9) == 0) send_cmd(ACT_CLEAR);
    end else begin
      repeat ($urandom_range(6, 1))
        send_item(cam_action_e'($urandom_range(7)), 8'($urandom), 1'($urandom),
                  1'($urandom), 15'($urandom));
    end
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct, bit rising);
    int unsigned start;
    write_end_edge(rising);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS / 4) random_sequence();
    wait_idle();
  endtask

  initial begin
    reset_capture_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 1'b0);
    test_random_phase(71, 0, 1'b1);
    test_random_phase(0, 71, 1'b0);
    test_random_phase(26, 26, 1'($urandom_range(1)));
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
